// File: hw/rtl/cam_actuator_pulse_sequencer_macros.svh
// assertion macros for the cam actuator pulse sequencer checker
// no dependencies; included by files that hold concurrent assertions
`ifndef CAM_ACTUATOR_PULSE_SEQUENCER_MACROS_SVH
`define CAM_ACTUATOR_PULSE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define CAPS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CAPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/caps_pkg.sv
// types, codes and constants of the cam actuator pulse sequencer
// no dependencies; used by the top level
package caps_pkg;

   typedef enum logic [1:0] {
      ACT_TYPE1  = 2'd0,
      ACT_TYPE2  = 2'd1,
      ACT_TYPE3  = 2'd2,
      ACT_ABSENT = 2'd3
   } caps_act_type;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SET  = 1'b1;

   localparam logic [1:0] CSR_ACT_TYPE = 2'd0;
   localparam logic [1:0] CSR_TABLE_LO = 2'd1;
   localparam logic [1:0] CSR_TABLE_HI = 2'd2;

   localparam logic [2:0] NPOS_SHORT = 3'd3;
   localparam logic [2:0] NPOS_LONG  = 3'd6;

   // reference sequence ends
   localparam logic [3:0] REF_LAST_T1 = 4'd3;
   localparam logic [3:0] REF_LAST_T2 = 4'd6;
   localparam logic [3:0] REF_LAST_T3 = 4'd13;

   // increment sequence bounds
   localparam logic [4:0] INC_FIRST_T1 = 5'd4;
   localparam logic [3:0] INC_LAST_T1  = 4'd5;
   localparam logic [4:0] INC_FIRST_T2 = 5'd7;
   localparam logic [3:0] INC_LAST_T2  = 4'd8;
   localparam logic [4:0] INC_FIRST_T3 = 5'd14;
   localparam logic [3:0] INC_LAST_T3  = 4'd15;

   // reference loop on type 3
   localparam logic [4:0] LOOP_END_STEP   = 5'd14;
   localparam logic [4:0] LOOP_START_STEP = 5'd2;

   typedef struct packed {
      logic       drive;
      logic [2:0] position;
      logic       reached;
   } caps_result_type;

   function automatic logic [2:0] caps_num_positions(caps_act_type act);
      return (act == ACT_TYPE3) ? NPOS_LONG : NPOS_SHORT;
   endfunction

endpackage

// File: hw/rtl/cam_actuator_pulse_sequencer.sv
// top level of the cam actuator pulse sequencer: state, pulse walk, result buffer
// depends on caps_pkg
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_cmd, req_target_position, req_sync_request
//  rsp     | out       | rsp_valid/rsp_stall | rsp_drive, rsp_current_position,
//          |           |                     | rsp_position_reached
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// one item per cycle while req_stall is low; each result is registered in the buffer
// the whole step is one pass of logic from the state registers to the result register
// a two-entry result buffer (output register plus skid) keeps req_stall registered
// req_stall rises only when both entries are full
// reset is synchronous; csr_ready is always high
module cam_actuator_pulse_sequencer
   import caps_pkg::*;
#(
   parameter int TICKS_PER_UNIT = 10,
   parameter int REF_LOOPS      = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_target_position,
   input  logic        req_sync_request,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_drive,
   output logic [2:0]  rsp_current_position,
   output logic        rsp_position_reached,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   caps_act_type act_type_ff, act_type_in;
   logic [63:0]  table_lo_ff, table_lo_in;
   logic [63:0]  table_hi_ff, table_hi_in;
   logic [7:0]   req_pos_ff, req_pos_in;
   logic [2:0]   pos_ff, pos_in;
   logic         sync_ff, sync_in;
   logic         wait_ff, wait_in;
   logic         inc_ff, inc_in;
   logic [4:0]   step_ff, step_in;
   logic [3:0]   last_ff, last_in;
   logic [3:0]   tick_ff, tick_in;
   logic [7:0]   unit_ff, unit_in;
   logic [2:0]   loops_ff, loops_in;
   logic         drive_ff, drive_in;

   logic            out_valid_ff, out_valid_in;
   caps_result_type out_ff, out_in;
   logic            skid_valid_ff, skid_valid_in;
   caps_result_type skid_ff, skid_in;

   logic            accept, out_fire, csr_we;
   logic [2:0]      n_now, n_cfg;
   caps_result_type new_res;
   logic [127:0]    table_all;

   logic [4:0] a_step;
   logic [3:0] a_last;
   logic [3:0] a_tick;
   logic [7:0] a_unit;
   logic [2:0] a_loops;
   logic [2:0] a_pos;
   logic       a_wait;
   logic       a_sync;

   logic       w_done;
   logic [4:0] w_step;
   logic [3:0] w_tick;
   logic [7:0] w_unit;
   logic [2:0] w_loops;
   logic       w_drive;
   logic [7:0] w_limit;

   logic [4:0] inc_first;
   logic [3:0] inc_last;
   logic [3:0] ref_last;

   assign accept    = req_valid && !req_stall;
   assign out_fire  = out_valid_ff && !rsp_stall;
   assign csr_we    = csr_valid && csr_ready;
   assign n_now     = caps_num_positions(act_type_ff);
   assign n_cfg     = caps_num_positions(caps_act_type'(csr_data[1:0]));
   assign table_all = {table_hi_ff, table_lo_ff};

   always_comb begin
      unique case (act_type_ff)
         ACT_TYPE1: begin
            ref_last  = REF_LAST_T1;
            inc_first = INC_FIRST_T1;
            inc_last  = INC_LAST_T1;
         end
         ACT_TYPE2: begin
            ref_last  = REF_LAST_T2;
            inc_first = INC_FIRST_T2;
            inc_last  = INC_LAST_T2;
         end
         default: begin
            ref_last  = REF_LAST_T3;
            inc_first = INC_FIRST_T3;
            inc_last  = INC_LAST_T3;
         end
      endcase
   end

   // pending sync starts the reference sequence
   always_comb begin
      a_step  = step_ff;
      a_last  = last_ff;
      a_tick  = tick_ff;
      a_unit  = unit_ff;
      a_loops = loops_ff;
      a_pos   = pos_ff;
      a_wait  = wait_ff;
      a_sync  = sync_ff;
      if (sync_ff) begin
         a_step  = '0;
         a_last  = ref_last;
         a_loops = (act_type_ff == ACT_TYPE3) ? 3'(REF_LOOPS) : 3'd0;
         a_tick  = '0;
         a_unit  = '0;
         a_wait  = 1'b1;
         a_pos   = n_now;
         a_sync  = 1'b0;
      end
   end

   // one step of the pulse walk
   always_comb begin
      w_done  = a_step > {1'b0, a_last};
      w_step  = a_step;
      w_tick  = a_tick;
      w_unit  = a_unit;
      w_loops = a_loops;
      w_drive = 1'b0;
      w_limit = table_all[{a_step[3:0], 3'b000} +: 8];
      if (!w_done) begin
         w_tick = a_tick + 4'd1;
         if (w_tick >= 4'(TICKS_PER_UNIT)) begin
            w_unit = a_unit + 8'd1;
            w_tick = '0;
         end
         if (w_unit < w_limit) begin
            w_drive = (act_type_ff == ACT_TYPE3) ? !a_step[0] : a_step[0];
         end else begin
            w_step = a_step + 5'd1;
            if (a_loops != 3'd0 && w_step == LOOP_END_STEP) begin
               w_loops = a_loops - 3'd1;
               w_step  = LOOP_START_STEP;
            end
            w_unit = '0;
         end
      end
   end

   always_comb begin
      act_type_in = act_type_ff;
      table_lo_in = table_lo_ff;
      table_hi_in = table_hi_ff;
      req_pos_in  = req_pos_ff;
      pos_in      = pos_ff;
      sync_in     = sync_ff;
      wait_in     = wait_ff;
      inc_in      = inc_ff;
      step_in     = step_ff;
      last_in     = last_ff;
      tick_in     = tick_ff;
      unit_in     = unit_ff;
      loops_in    = loops_ff;
      drive_in    = drive_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_ACT_TYPE: begin
               act_type_in = caps_act_type'(csr_data[1:0]);
               sync_in     = 1'b0;
               wait_in     = 1'b0;
               inc_in      = 1'b0;
               req_pos_in  = {5'd0, n_cfg};
               pos_in      = n_cfg;
            end
            CSR_TABLE_LO: table_lo_in = csr_data;
            CSR_TABLE_HI: table_hi_in = csr_data;
            default: ;
         endcase
      end

      if (accept) begin
         if (req_cmd == CMD_SET) begin
            sync_in    = req_sync_request;
            req_pos_in = req_target_position;
         end else if (act_type_ff != ACT_ABSENT) begin
            step_in  = a_step;
            last_in  = a_last;
            tick_in  = a_tick;
            unit_in  = a_unit;
            loops_in = a_loops;
            pos_in   = a_pos;
            wait_in  = a_wait;
            sync_in  = a_sync;
            if (a_wait) begin
               step_in  = w_step;
               tick_in  = w_tick;
               unit_in  = w_unit;
               loops_in = w_loops;
               drive_in = w_drive;
               if (w_done) begin
                  pos_in  = '0;
                  inc_in  = 1'b0;
                  wait_in = 1'b0;
               end
            end else if (req_pos_ff != {5'd0, a_pos} && req_pos_ff < {5'd0, n_now}) begin
               if (a_pos >= n_now) begin
                  sync_in = 1'b1;
               end else if (!inc_ff) begin
                  step_in  = inc_first;
                  last_in  = inc_last;
                  loops_in = '0;
                  tick_in  = '0;
                  unit_in  = '0;
                  inc_in   = 1'b1;
               end else begin
                  step_in  = w_step;
                  tick_in  = w_tick;
                  unit_in  = w_unit;
                  loops_in = w_loops;
                  drive_in = w_drive;
                  if (w_done) begin
                     pos_in = (a_pos < n_now - 3'd1) ? a_pos + 3'd1 : 3'd0;
                     inc_in = 1'b0;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      new_res.drive    = drive_in;
      new_res.position = pos_in;
      new_res.reached  = (req_pos_in == {5'd0, pos_in}) && (pos_in < n_now);
   end

   // result buffer
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (accept) begin
         if (!out_valid_ff || out_fire) begin
            out_valid_in = 1'b1;
            out_in       = new_res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = new_res;
         end
      end else if (out_fire) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_type_ff   <= ACT_ABSENT;
         table_lo_ff   <= '0;
         table_hi_ff   <= '0;
         req_pos_ff    <= {5'd0, NPOS_SHORT};
         pos_ff        <= NPOS_SHORT;
         sync_ff       <= 1'b0;
         wait_ff       <= 1'b0;
         inc_ff        <= 1'b0;
         step_ff       <= '0;
         last_ff       <= '0;
         tick_ff       <= '0;
         unit_ff       <= '0;
         loops_ff      <= '0;
         drive_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         act_type_ff   <= act_type_in;
         table_lo_ff   <= table_lo_in;
         table_hi_ff   <= table_hi_in;
         req_pos_ff    <= req_pos_in;
         pos_ff        <= pos_in;
         sync_ff       <= sync_in;
         wait_ff       <= wait_in;
         inc_ff        <= inc_in;
         step_ff       <= step_in;
         last_ff       <= last_in;
         tick_ff       <= tick_in;
         unit_ff       <= unit_in;
         loops_ff      <= loops_in;
         drive_ff      <= drive_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall            = skid_valid_ff;
   assign rsp_valid            = out_valid_ff;
   assign rsp_drive            = out_ff.drive;
   assign rsp_current_position = out_ff.position;
   assign rsp_position_reached = out_ff.reached;
   assign csr_ready            = 1'b1;

endmodule

// File: hw/rtl/caps_checker.sv
// port-level checks of the cam actuator pulse sequencer, bound to the top level
// depends on cam_actuator_pulse_sequencer_macros.svh
`include "cam_actuator_pulse_sequencer_macros.svh"

module caps_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_current_position,
   input logic       rsp_position_reached
);

   `CAPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")
   `CAPS_ASSERT_IMPLY(a_stall_full, clock, reset, req_stall, rsp_valid, "req stalled with empty result buffer")
   `CAPS_ASSERT_IMPLY(a_pos_range, clock, reset, rsp_valid, rsp_current_position != 3'd7, "position out of range")
   `CAPS_ASSERT_IMPLY(a_reached_defined, clock, reset, rsp_valid && rsp_position_reached, rsp_current_position != 3'd6 && rsp_current_position != 3'd7, "reached on undefined position")

endmodule

bind cam_actuator_pulse_sequencer caps_checker u_caps_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_current_position (rsp_current_position),
   .rsp_position_reached (rsp_position_reached)
);

// File: dv/caps_result_checker.sv
// result checker for the cam actuator pulse sequencer: predicts every result and compares it
// depends on caps_pkg; instantiated beside the block by tb_cam_actuator_pulse_sequencer
`timescale 1ns / 100ps

module caps_result_checker
   import caps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_target_position,
   input  logic        req_sync_request,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_drive,
   input  logic [2:0]  rsp_current_position,
   input  logic        rsp_position_reached,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          pending_results
);

   localparam int TICKS_PER_UNIT = 10;
   localparam int REF_LOOPS      = 5;

   caps_act_type act;
   logic [63:0]  tbl_lo;
   logic [63:0]  tbl_hi;
   logic [7:0]   want_pos;
   logic [2:0]   pos_now;
   logic         sync_pend;
   logic         sync_run;
   logic         inc_run;
   logic [4:0]   step_idx;
   logic [3:0]   step_end;
   logic [3:0]   tick_cnt;
   logic [7:0]   unit_cnt;
   logic [2:0]   loops;
   logic         drv;

   caps_result_type expected_q[$];
   caps_result_type got;
   caps_result_type want;

   function automatic logic [2:0] position_count(caps_act_type t);
      return (t == ACT_TYPE3) ? NPOS_LONG : NPOS_SHORT;
   endfunction

   function automatic logic [7:0] step_time(logic [63:0] lo, logic [63:0] hi, logic [4:0] s);
      logic [63:0] w;
      w = s[3] ? hi : lo;
      return w[s[2:0] * 8 +: 8];
   endfunction

   task report_mismatch(string what, int exp_v, int got_v);
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
      fail_count++;
   endtask

   task home_flags();
      sync_pend = 1'b0;
      sync_run  = 1'b0;
      inc_run   = 1'b0;
      want_pos  = {5'd0, position_count(act)};
      pos_now   = position_count(act);
   endtask

   task begin_sequence(bit homing);
      loops = '0;
      if (homing) begin
         step_idx = '0;
         case (act)
            ACT_TYPE1: step_end = REF_LAST_T1;
            ACT_TYPE2: step_end = REF_LAST_T2;
            default: begin
               step_end = REF_LAST_T3;
               loops    = REF_LOOPS[2:0];
            end
         endcase
      end else begin
         case (act)
            ACT_TYPE1: begin
               step_idx = INC_FIRST_T1;
               step_end = INC_LAST_T1;
            end
            ACT_TYPE2: begin
               step_idx = INC_FIRST_T2;
               step_end = INC_LAST_T2;
            end
            default: begin
               step_idx = INC_FIRST_T3;
               step_end = INC_LAST_T3;
            end
         endcase
      end
      tick_cnt = '0;
      unit_cnt = '0;
   endtask

   task walk_pulse(output bit done);
      logic lvl;
      lvl  = 1'b0;
      done = 1'b0;
      if (step_idx > {1'b0, step_end}) begin
         done = 1'b1;
      end else begin
         tick_cnt = tick_cnt + 4'd1;
         if (tick_cnt >= 4'(TICKS_PER_UNIT)) begin
            unit_cnt = unit_cnt + 8'd1;
            tick_cnt = '0;
         end
         if (unit_cnt < step_time(tbl_lo, tbl_hi, step_idx)) begin
            lvl = (act == ACT_TYPE3) ? ~step_idx[0] : step_idx[0];
         end else begin
            step_idx = step_idx + 5'd1;
            if (loops != 3'd0 && step_idx == LOOP_END_STEP) begin
               loops    = loops - 3'd1;
               step_idx = LOOP_START_STEP;
            end
            unit_cnt = '0;
         end
      end
      drv = lvl;
   endtask

   task apply_tick();
      logic [2:0] n;
      bit         done;
      n = position_count(act);
      if (act != ACT_ABSENT) begin
         if (sync_pend) begin
            begin_sequence(1'b1);
            sync_run  = 1'b1;
            pos_now   = n;
            sync_pend = 1'b0;
         end
         if (sync_run) begin
            walk_pulse(done);
            if (done) begin
               pos_now  = '0;
               inc_run  = 1'b0;
               sync_run = 1'b0;
            end
         end else if (want_pos != {5'd0, pos_now} && want_pos < {5'd0, n}) begin
            if (pos_now >= n) begin
               sync_pend = 1'b1;
            end else if (!inc_run) begin
               begin_sequence(1'b0);
               inc_run = 1'b1;
            end else begin
               walk_pulse(done);
               if (done) begin
                  pos_now = (pos_now < n - 3'd1) ? pos_now + 3'd1 : 3'd0;
                  inc_run = 1'b0;
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         act    = ACT_ABSENT;
         tbl_lo = '0;
         tbl_hi = '0;
         home_flags();
         step_idx = '0;
         step_end = '0;
         tick_cnt = '0;
         unit_cnt = '0;
         loops    = '0;
         drv      = 1'b0;
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{drive: rsp_drive, position: rsp_current_position,
                    reached: rsp_position_reached};
            if (expected_q.size() == 0) begin
               report_mismatch("result with nothing expected", 0, 1);
            end else begin
               want = expected_q.pop_front();
               if (got.drive !== want.drive)
                  report_mismatch("drive", int'(want.drive), int'(got.drive));
               if (got.position !== want.position)
                  report_mismatch("current_position", int'(want.position),
                                  int'(got.position));
               if (got.reached !== want.reached)
                  report_mismatch("position_reached", int'(want.reached),
                                  int'(got.reached));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACT_TYPE: begin
                  act = caps_act_type'(csr_data[1:0]);
                  home_flags();
               end
               CSR_TABLE_LO: tbl_lo = csr_data;
               CSR_TABLE_HI: tbl_hi = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_cmd == CMD_SET) begin
               sync_pend = req_sync_request;
               want_pos  = req_target_position;
            end else begin
               apply_tick();
            end
            want.drive    = drv;
            want.position = pos_now;
            want.reached  = (want_pos == {5'd0, pos_now}) && (pos_now < position_count(act));
            expected_q.push_back(want);
         end
      end
      pending_results = expected_q.size();
   end

endmodule

// File: dv/tb_cam_actuator_pulse_sequencer.sv
// testbench top for the cam actuator pulse sequencer: clock, reset, stimulus and verdict
// depends on caps_pkg, the block and caps_result_checker
`timescale 1ns / 100ps

module tb_cam_actuator_pulse_sequencer
   import caps_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = CMD_TICK;
   logic [7:0]  req_target_position = '0;
   logic        req_sync_request = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_drive;
   logic [2:0]  rsp_current_position;
   logic        rsp_position_reached;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_ACT_TYPE;
   logic [63:0] csr_data = '0;

   int           fail_count;
   int           pending_results;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   caps_act_type cur_type = ACT_ABSENT;

   always #5 clock = ~clock;

   cam_actuator_pulse_sequencer i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_target_position  (req_target_position),
      .req_sync_request     (req_sync_request),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_drive            (rsp_drive),
      .rsp_current_position (rsp_current_position),
      .rsp_position_reached (rsp_position_reached),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   caps_result_checker u_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_target_position  (req_target_position),
      .req_sync_request     (req_sync_request),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_drive            (rsp_drive),
      .rsp_current_position (rsp_current_position),
      .rsp_position_reached (rsp_position_reached),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .fail_count           (fail_count),
      .pending_results      (pending_results)
   );

   always @(negedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [63:0] rand_table(int maxb, int pct_nonzero);
      logic [63:0] w;
      w = '0;
      for (int i = 0; i < 8; i++) begin
         if ($urandom_range(99) < pct_nonzero)
            w[i * 8 +: 8] = 8'($urandom_range(maxb));
      end
      return w;
   endfunction

   task send_item(logic cmd, logic [7:0] tgt, logic sync);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_cmd             <= cmd;
      req_target_position <= tgt;
      req_sync_request    <= sync;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task write_reg(logic [1:0] idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task configure(caps_act_type t, logic [63:0] lo, logic [63:0] hi);
      while (pending_results != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      write_reg(CSR_TABLE_LO, lo);
      write_reg(CSR_TABLE_HI, hi);
      write_reg(CSR_ACT_TYPE, 64'(t));
      csr_valid <= 1'b0;
      cur_type = t;
      @(negedge clock);
   endtask

   task random_item();
      logic [2:0] n;
      int         r;
      n = (cur_type == ACT_TYPE3) ? NPOS_LONG : NPOS_SHORT;
      r = $urandom_range(99);
      if (r < 78)
         send_item(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (r < 93)
         send_item(CMD_SET, 8'($urandom_range(n)), ($urandom_range(3) == 0));
      else
         send_item(CMD_SET, 8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   task run_phase(int mode, caps_act_type t, logic [63:0] lo, logic [63:0] hi, int count);
      configure(t, lo, hi);
      case (mode)
         1: begin
            send_idle_pct = 60;
            stall_pct     = 0;
         end
         2: begin
            send_idle_pct = 0;
            stall_pct     = 60;
         end
         3: begin
            send_idle_pct = 17;
            stall_pct     = 17;
         end
         default: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
      endcase
      repeat (count) random_item();
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // absent actuator ignores ticks
      send_item(CMD_TICK, 8'd0, 1'b0);
      send_item(CMD_SET, 8'd255, 1'b1);
      send_item(CMD_TICK, 8'd0, 1'b0);
      req_valid <= 1'b0;

      // undefined position forces a sync, then one increment
      configure(ACT_TYPE1, 64'd0, 64'd0);
      send_item(CMD_SET, 8'd1, 1'b0);
      repeat (10) send_item(CMD_TICK, 8'd0, 1'b0);
      send_item(CMD_SET, 8'd255, 1'b0);
      send_item(CMD_TICK, 8'd255, 1'b1);
      send_item(CMD_SET, 8'd0, 1'b1);
      repeat (6) send_item(CMD_TICK, 8'd0, 1'b0);
      req_valid <= 1'b0;

      run_phase(0, ACT_TYPE1, rand_table(2, 60), rand_table(2, 60), 85);
      run_phase(1, ACT_TYPE2, rand_table(2, 60), rand_table(2, 60), 85);
      run_phase(2, ACT_TYPE3, rand_table(1, 20), rand_table(1, 20), 85);
      run_phase(3, ACT_TYPE3, rand_table(2, 30), rand_table(2, 30), 85);
      run_phase(0, ACT_ABSENT, {$urandom, $urandom}, {$urandom, $urandom}, 40);
      run_phase(1, ACT_TYPE1, '1, '0, 60);
      run_phase(2, ACT_TYPE3, '0, '1, 60);
      run_phase(3, ACT_TYPE2, rand_table(3, 50), rand_table(3, 50), 85);
      run_phase(0, ACT_TYPE1, rand_table(1, 100), rand_table(1, 100), 85);
      run_phase(1, ACT_TYPE3, rand_table(1, 20), rand_table(1, 20), 85);

      while (pending_results != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
